/* rtl/rpvs_pkg.sv */
package rpvs_pkg;

	// field widths of the input and result words
	localparam int SCORE_W = 17;
	localparam int MATCH_W = 16;
	localparam int DRAW_W  = 16;
	localparam int OUT_W   = 10;
	localparam int VAL_W   = 17;

	// serial divider widths: 2^32 dividend, divisor up to 2^17
	localparam int DIVD_W  = 33;
	localparam int DIVS_W  = 18;

	// opcodes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_SELECT = 2'd2;

	// 1.0 in Q1.16
	localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVF_GO,
		ST_DIVF_WAIT,
		ST_DIVI_GO,
		ST_DIVI_WAIT,
		ST_MUL,
		ST_WALK,
		ST_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clear_pop;
		logic div_start_f;
		logic fit_latch;
		logic div_start_i;
		logic write_entry;
		logic mul_step;
		logic walk_start;
		logic publish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic div_done;
		logic mul_last;
		logic walk_done;
	} sts_t;

endpackage

/* rtl/roulette_parent_and_victim_select_core.sv */
// Channel   Handshake                 Payload
// command   start / busy              opcode, score_halves, match_count, draw_a..draw_d
// result    result_valid (1 cycle)    parent_a_index, parent_b_index, victim_a_index,
//                                     victim_b_index, empty_flag
//
// A word is taken when start is high and busy is low; busy stays high until it is done.
// Clear, unused opcodes and a load into a full population finish at the taking edge.
// Load holds busy through two 33-step divider passes, each with a launch state and a done wait.
// Select holds busy through a target multiply per draw, reads of the N stored entries, the s1
// and s2 pipeline registers and a publish state (just the publish state on an empty population);
// the result word follows in the next cycle, shown for one cycle; the receiver cannot stall it.
// Reset (arst_n low) empties the population; no clearing pass over the memory is needed.
module roulette_parent_and_victim_select_core #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    opcode,
	input  logic [rpvs_pkg::SCORE_W-1:0]  score_halves,
	input  logic [rpvs_pkg::MATCH_W-1:0]  match_count,
	input  logic [rpvs_pkg::DRAW_W-1:0]   draw_a,
	input  logic [rpvs_pkg::DRAW_W-1:0]   draw_b,
	input  logic [rpvs_pkg::DRAW_W-1:0]   draw_c,
	input  logic [rpvs_pkg::DRAW_W-1:0]   draw_d,
	output logic                          result_valid,
	output logic [rpvs_pkg::OUT_W-1:0]    parent_a_index,
	output logic [rpvs_pkg::OUT_W-1:0]    parent_b_index,
	output logic [rpvs_pkg::OUT_W-1:0]    victim_a_index,
	output logic [rpvs_pkg::OUT_W-1:0]    victim_b_index,
	output logic                          empty_flag
);
	import rpvs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	rpvs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	// store, divider, targets and wheel walk
	rpvs_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.score_halves   (score_halves),
		.match_count    (match_count),
		.draw_a         (draw_a),
		.draw_b         (draw_b),
		.draw_c         (draw_c),
		.draw_d         (draw_d),
		.parent_a_index (parent_a_index),
		.parent_b_index (parent_b_index),
		.victim_a_index (victim_a_index),
		.victim_b_index (victim_b_index),
		.empty_flag     (empty_flag),
		.result_valid   (result_valid)
	);

endmodule

/* rtl/rpvs_div.sv */
module rpvs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rpvs_pkg::DIVD_W-1:0]  dividend,
	input  logic [rpvs_pkg::DIVS_W-1:0]  divisor,
	output logic                         done,
	output logic [rpvs_pkg::DIVD_W-1:0]  quotient
);
	import rpvs_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic [DIVD_W-1:0] dq_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;

	logic [DIVS_W:0]   rem_sh;
	logic [DIVS_W:0]   diff;
	logic              ge;

	// one restoring step: shift in the next dividend bit, try subtract
	always_comb begin
		rem_sh = {rem_q, dq_q[DIVD_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		diff   = rem_sh - {1'b0, dvs_q};
	end

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			dq_q  <= {dq_q[DIVD_W-2:0], ge};
			rem_q <= ge ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

/* rtl/rpvs_ctrl.sv */
module rpvs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         opcode,
	output logic               busy,
	output rpvs_pkg::cmd_t     cmd,
	input  rpvs_pkg::sts_t     sts
);
	import rpvs_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					case (opcode)
						OP_CLEAR: begin
							cmd.clear_pop = 1'b1;
						end
						OP_LOAD: begin
							if (!sts.full) begin
								state_d = ST_DIVF_GO;
							end
						end
						OP_SELECT: begin
							state_d = sts.empty ? ST_RESULT : ST_MUL;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_DIVF_GO: begin
				cmd.div_start_f = 1'b1;
				state_d = ST_DIVF_WAIT;
			end
			ST_DIVF_WAIT: begin
				if (sts.div_done) begin
					cmd.fit_latch = 1'b1;
					state_d = ST_DIVI_GO;
				end
			end
			ST_DIVI_GO: begin
				cmd.div_start_i = 1'b1;
				state_d = ST_DIVI_WAIT;
			end
			ST_DIVI_WAIT: begin
				if (sts.div_done) begin
					cmd.write_entry = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) begin
					cmd.walk_start = 1'b1;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.walk_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				cmd.publish = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* rtl/rpvs_dp.sv */
module rpvs_dp #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rpvs_pkg::cmd_t                cmd,
	output rpvs_pkg::sts_t                sts,
	input  logic [rpvs_pkg::SCORE_W-1:0]  score_halves,
	input  logic [rpvs_pkg::MATCH_W-1:0]  match_count,
	input  logic [rpvs_pkg::DRAW_W-1:0]   draw_a,
	input  logic [rpvs_pkg::DRAW_W-1:0]   draw_b,
	input  logic [rpvs_pkg::DRAW_W-1:0]   draw_c,
	input  logic [rpvs_pkg::DRAW_W-1:0]   draw_d,
	output logic [rpvs_pkg::OUT_W-1:0]    parent_a_index,
	output logic [rpvs_pkg::OUT_W-1:0]    parent_b_index,
	output logic [rpvs_pkg::OUT_W-1:0]    victim_a_index,
	output logic [rpvs_pkg::OUT_W-1:0]    victim_b_index,
	output logic                          empty_flag,
	output logic                          result_valid
);
	import rpvs_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int TW = VAL_W + IW;
	localparam int PW = TW + DRAW_W;
	localparam int NLANE = 4;

	// captured word
	logic [SCORE_W-1:0] score_q;
	logic [MATCH_W-1:0] match_q;
	logic [DRAW_W-1:0]  draw_q [NLANE];

	// population state
	logic [CW-1:0]      count_q;
	logic [TW-1:0]      ftot_q;
	logic [TW-1:0]      itot_q;
	logic [VAL_W-1:0]   fit_q;
	logic [2*VAL_W-1:0] mem [MAX_ENTRIES];

	// divider
	logic               div_start;
	logic [DIVD_W-1:0]  div_dvd;
	logic [DIVS_W-1:0]  div_dvs;
	logic               div_done;
	logic [DIVD_W-1:0]  div_quo;
	logic [VAL_W-1:0]   fit_next;

	// targets
	logic [1:0]         mul_cnt_q;
	logic [PW-1:0]      target_q [NLANE];
	logic [PW-1:0]      prod;

	// walk pipeline
	logic               issue_q;
	logic [IW-1:0]      addr_q;
	logic [IW-1:0]      last_idx;
	logic               vld_s1;
	logic [IW-1:0]      idx_s1;
	logic [2*VAL_W-1:0] rd_s1;
	logic               vld_s2;
	logic [IW-1:0]      idx_s2;
	logic [TW-1:0]      cum_f_q;
	logic [TW-1:0]      cum_i_q;
	logic [PW-1:0]      cum_f_sh;
	logic [PW-1:0]      cum_i_sh;
	logic [NLANE-1:0]   found_q;
	logic [NLANE-1:0]   hit;
	logic [IW-1:0]      lane_idx_q [NLANE];

	// result word
	logic [OUT_W-1:0]   out_idx_q [NLANE];
	logic               empty_q;
	logic               valid_q;

	assign last_idx = IW'(count_q - 1'b1);

	// capture of the incoming word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			score_q   <= score_halves;
			match_q   <= match_count;
			draw_q[0] <= draw_a;
			draw_q[1] <= draw_b;
			draw_q[2] <= draw_c;
			draw_q[3] <= draw_d;
		end
	end

	// shared divider: score*32768/matches, then 2^32/(1+fitness)
	assign div_start = cmd.div_start_f | cmd.div_start_i;
	always_comb begin
		if (cmd.div_start_i) begin
			div_dvd = {1'b1, {(DIVD_W-1){1'b0}}};
			div_dvs = DIVS_W'(ONE_Q16) + DIVS_W'(fit_q);
		end else begin
			div_dvd = {1'b0, score_q, 15'b0};
			div_dvs = DIVS_W'(match_q);
		end
	end

	rpvs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// fitness: zero without matches, saturated at 1.0
	always_comb begin
		if (match_q == '0) begin
			fit_next = '0;
		end else if (div_quo > DIVD_W'(ONE_Q16)) begin
			fit_next = ONE_Q16;
		end else begin
			fit_next = div_quo[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fit_latch) begin
			fit_q <= fit_next;
		end
	end

	// entry store
	always_ff @(posedge clk) begin
		if (cmd.write_entry) begin
			mem[count_q[IW-1:0]] <= {fit_q, div_quo[VAL_W-1:0]};
		end
		if (issue_q) begin
			rd_s1 <= mem[addr_q];
		end
	end

	// count and running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ftot_q  <= '0;
			itot_q  <= '0;
		end else if (cmd.clear_pop) begin
			count_q <= '0;
			ftot_q  <= '0;
			itot_q  <= '0;
		end else if (cmd.write_entry) begin
			count_q <= count_q + 1'b1;
			ftot_q  <= ftot_q + TW'(fit_q);
			itot_q  <= itot_q + TW'(div_quo[VAL_W-1:0]);
		end
	end

	// one target per cycle: draw times the matching total
	assign prod = PW'(draw_q[mul_cnt_q]) * PW'(mul_cnt_q[1] ? itot_q : ftot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q <= '0;
		end else if (cmd.capture) begin
			mul_cnt_q <= '0;
		end else if (cmd.mul_step) begin
			mul_cnt_q <= mul_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			target_q[mul_cnt_q] <= prod;
		end
	end

	// read issue over entries 0..count-1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			addr_q  <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			vld_s1 <= issue_q;
			vld_s2 <= vld_s1;
			if (cmd.walk_start) begin
				issue_q <= 1'b1;
				addr_q  <= '0;
			end else if (issue_q) begin
				if (addr_q == last_idx) begin
					issue_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
		end
	end

	// cumulative sums
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		if (cmd.walk_start) begin
			cum_f_q <= '0;
			cum_i_q <= '0;
		end else if (vld_s1) begin
			cum_f_q <= cum_f_q + TW'(rd_s1[2*VAL_W-1:VAL_W]);
			cum_i_q <= cum_i_q + TW'(rd_s1[VAL_W-1:0]);
		end
	end

	// first index whose scaled sum reaches the target, per lane
	assign cum_f_sh = {cum_f_q, {DRAW_W{1'b0}}};
	assign cum_i_sh = {cum_i_q, {DRAW_W{1'b0}}};

	always_comb begin
		for (int k = 0; k < NLANE; k++) begin
			hit[k] = vld_s2 && !found_q[k]
				&& (((k < 2) ? cum_f_sh : cum_i_sh) >= target_q[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
		end else if (cmd.walk_start) begin
			found_q <= '0;
		end else begin
			found_q <= found_q | hit;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NLANE; k++) begin
			if (hit[k]) begin
				lane_idx_q[k] <= idx_s2;
			end
		end
	end

	// result word, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.publish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			empty_q <= sts.empty;
			for (int k = 0; k < NLANE; k++) begin
				out_idx_q[k] <= sts.empty ? '0 : OUT_W'(lane_idx_q[k]);
			end
		end
	end

	assign parent_a_index = out_idx_q[0];
	assign parent_b_index = out_idx_q[1];
	assign victim_a_index = out_idx_q[2];
	assign victim_b_index = out_idx_q[3];
	assign empty_flag     = empty_q;
	assign result_valid   = valid_q;

	// status back to the controller
	always_comb begin
		sts.full      = (count_q == CW'(MAX_ENTRIES));
		sts.empty     = (count_q == '0);
		sts.div_done  = div_done;
		sts.mul_last  = (mul_cnt_q == 2'd3);
		sts.walk_done = vld_s2 && (idx_s2 == last_idx);
	end

endmodule
